FILE: rtl/core/eoe_pkg.sv
// Package for the Exif orientation extractor: constants, marker tables and the
// command/status types exchanged between eoe_ctrl and eoe_dp. No dependencies.
`timescale 1ns / 1ps

package eoe_pkg;

  // Default payload store depth, and the width of payload positions and counts.
  localparam int unsigned MAX_PAYLOAD_DEF = 4096;
  localparam int unsigned PW              = 17;

  localparam logic [15:0]   HDR_LEN     = 16'd8;   // length field + "Exif\0\0"
  localparam logic [PW-1:0] MIN_PAYLOAD = 17'd12;  // minimum payload length
  localparam logic [15:0]   ENTRY_SIZE  = 16'd12;  // bytes per IFD entry
  localparam logic [PW-1:0] VALUE_OFS   = 17'd8;   // value field within an entry
  localparam logic [15:0]   MARK_MM     = 16'h4D4D;
  localparam logic [15:0]   MARK_II     = 16'h4949;
  localparam logic [15:0]   TIFF_MAGIC  = 16'd42;
  localparam logic [15:0]   TAG_ORIENT  = 16'h0112;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLR,
    CNT_INC
  } cnt_op_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_OFF,
    PTR_IDX,
    PTR_VAL
  } ptr_op_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_OFF2,
    IDX_STEP
  } idx_op_e;

  typedef enum logic [1:0] {
    ENT_HOLD,
    ENT_LOAD,
    ENT_DEC
  } ent_op_e;

  typedef struct packed {
    cnt_op_e cnt_op;
    logic    len_shift;
    logic    plen_load;
    logic    mem_wr;
    ptr_op_e ptr_op;
    logic    rd;
    logic    shift;
    logic    le_load;
    idx_op_e idx_op;
    ent_op_e ent_op;
    logic    res_load;
    logic    res_fail;
    logic    res_val;
  } eoe_cmd_t;

  typedef struct packed {
    logic mark_ok;
    logic mark_end;
    logic len_end;
    logic len_short;
    logic hdr_ok;
    logic hdr_end;
    logic plen_bad;
    logic pay_end;
    logic mark_mm;
    logic mark_ii;
    logic tag_ok;
    logic off_bad;
    logic scan_end;
    logic tag_hit;
    logic out_free;
  } eoe_sts_t;

  // SOI followed by APP1
  function automatic logic [7:0] start_mark(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hFF;
      2'd1:    b = 8'hD8;
      2'd2:    b = 8'hFF;
      default: b = 8'hE1;
    endcase
    return b;
  endfunction

  // "Exif"
  function automatic logic [7:0] exif_char(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h45;
      2'd1:    b = 8'h78;
      2'd2:    b = 8'h69;
      default: b = 8'h66;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/eoe_dp.sv
// Datapath of the Exif orientation extractor: byte counter, length registers,
// payload store, IFD scan registers and the result register. Uses eoe_pkg.
`timescale 1ns / 1ps

module eoe_dp #(
  parameter int unsigned MAX_PAYLOAD = eoe_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       data_byte_i,
  input  logic             first_byte_i,
  input  eoe_pkg::eoe_cmd_t cmd_i,
  output eoe_pkg::eoe_sts_t sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             failed_o,
  output logic [15:0]      orientation_o
);
  import eoe_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PAYLOAD);

  logic [PW-1:0] cnt_q, cnt_d, cnt_eff;
  logic [15:0]   len_q, len_new, plen_q, plen_tmp;
  logic [PW-1:0] plen_x;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [PW-1:0] idx_q, idx_d;
  logic [15:0]   ent_q, ent_d;
  logic [31:0]   word_q;
  logic [7:0]    rdata_q;
  logic          le_q;
  logic [31:0]   off32;
  logic [15:0]   val16;
  logic          out_valid_q;
  logic          out_failed_q;
  logic [15:0]   out_orient_q;
  logic [7:0]    pay_mem [MAX_PAYLOAD];

  // A first byte is always byte 0 of the markers.
  assign cnt_eff  = first_byte_i ? '0 : cnt_q;
  assign len_new  = {len_q[7:0], data_byte_i};
  assign plen_tmp = len_q - HDR_LEN;
  assign plen_x   = {1'b0, plen_q};
  assign off32    = le_q ? {word_q[7:0], word_q[15:8], word_q[23:16], word_q[31:24]} : word_q;
  assign val16    = le_q ? {word_q[7:0], word_q[15:8]} : word_q[15:0];

  always_comb begin
    sts_o.mark_ok   = (data_byte_i == start_mark(cnt_eff[1:0]));
    sts_o.mark_end  = (cnt_eff == PW'(3));
    sts_o.len_end   = (cnt_eff == PW'(1));
    sts_o.len_short = (len_new < HDR_LEN);
    sts_o.hdr_ok    = (cnt_eff >= PW'(4)) || (data_byte_i == exif_char(cnt_eff[1:0]));
    sts_o.hdr_end   = (cnt_eff == PW'(5));
    sts_o.plen_bad  = ({1'b0, plen_tmp} < MIN_PAYLOAD) ||
                      ({1'b0, plen_tmp} > PW'(MAX_PAYLOAD));
    sts_o.pay_end   = ((cnt_eff + PW'(1)) >= plen_x);
    sts_o.mark_mm   = (word_q[31:16] == MARK_MM);
    sts_o.mark_ii   = (word_q[31:16] == MARK_II);
    sts_o.tag_ok    = (word_q[31:16] == MARK_MM) ? (word_q[15:0] == TIFF_MAGIC)
                                                 : ({word_q[7:0], word_q[15:8]} == TIFF_MAGIC);
    sts_o.off_bad   = (off32 > {16'd0, plen_q - 16'd2});
    sts_o.scan_end  = (ent_q == 16'd0) || (idx_q >= {1'b0, plen_q - ENTRY_SIZE});
    sts_o.tag_hit   = (val16 == TAG_ORIENT);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_CLR: cnt_d = '0;
      CNT_INC: cnt_d = cnt_eff + PW'(1);
      default: cnt_d = cnt_q;
    endcase

    rptr_d = cmd_i.rd ? rptr_q + PW'(1) : rptr_q;
    case (cmd_i.ptr_op)
      PTR_ZERO: rptr_d = '0;
      PTR_OFF:  rptr_d = off32[PW-1:0];
      PTR_IDX:  rptr_d = idx_q;
      PTR_VAL:  rptr_d = idx_q + VALUE_OFS;
      default:  ;
    endcase

    case (cmd_i.idx_op)
      IDX_OFF2: idx_d = off32[PW-1:0] + PW'(2);
      IDX_STEP: idx_d = idx_q + {1'b0, ENTRY_SIZE};
      default:  idx_d = idx_q;
    endcase

    case (cmd_i.ent_op)
      ENT_LOAD: ent_d = val16;
      ENT_DEC:  ent_d = ent_q - 16'd1;
      default:  ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_shift) begin
      len_q <= len_new;
    end
    if (cmd_i.plen_load) begin
      plen_q <= plen_tmp;
    end
    if (cmd_i.le_load) begin
      le_q <= sts_o.mark_ii;
    end
    if (cmd_i.shift) begin
      word_q <= {word_q[23:0], rdata_q};
    end
    rptr_q <= rptr_d;
    idx_q  <= idx_d;
    ent_q  <= ent_d;
    if (cmd_i.res_load) begin
      out_failed_q <= cmd_i.res_fail;
      out_orient_q <= cmd_i.res_val ? val16 : 16'd0;
    end
  end

  // Payload store: one write port for incoming bytes, one registered read for the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      pay_mem[cnt_q[AW-1:0]] <= data_byte_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= pay_mem[rptr_q[AW-1:0]];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign failed_o      = out_failed_q;
  assign orientation_o = out_orient_q;

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_failed_q |-> out_orient_q == 16'd0)
    else $error("failed item carries a nonzero orientation");

  a_rd_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> rptr_q < plen_x)
    else $error("scan reads beyond the stored payload");

  a_wr_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_wr |-> cnt_q < PW'(MAX_PAYLOAD))
    else $error("payload write beyond the store");
`endif

endmodule

FILE: rtl/core/eoe_ctrl.sv
// Controller of the Exif orientation extractor: parse phases for incoming bytes
// and the IFD scan sequencer. Drives eoe_dp through eoe_pkg command/status types.
`timescale 1ns / 1ps

module eoe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              first_byte_i,
  input  logic              last_byte_i,
  input  eoe_pkg::eoe_sts_t sts_i,
  output eoe_pkg::eoe_cmd_t cmd_o
);
  import eoe_pkg::*;

  localparam logic [3:0] S_MARK = 4'd0;
  localparam logic [3:0] S_LEN  = 4'd1;
  localparam logic [3:0] S_HDR  = 4'd2;
  localparam logic [3:0] S_PAY  = 4'd3;
  localparam logic [3:0] S_DONE = 4'd4;
  localparam logic [3:0] S_FRD  = 4'd5;
  localparam logic [3:0] S_FSH  = 4'd6;
  localparam logic [3:0] S_CK1  = 4'd7;
  localparam logic [3:0] S_CK2  = 4'd8;
  localparam logic [3:0] S_CK3  = 4'd9;
  localparam logic [3:0] S_LOOP = 4'd10;
  localparam logic [3:0] S_TAG  = 4'd11;
  localparam logic [3:0] S_VAL  = 4'd12;

  logic [3:0] state_q, state_d, ret_q, ret_d, st_eff;
  logic [1:0] fcnt_q, fcnt_d;
  logic       ingest, accept, fail, scan, ignore;

  assign ingest = (state_q == S_MARK) || (state_q == S_LEN) || (state_q == S_HDR) ||
                  (state_q == S_PAY) || (state_q == S_DONE);
  assign in_ready_o = ingest && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign st_eff     = first_byte_i ? S_MARK : state_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ret_d   = ret_q;
    fcnt_d  = fcnt_q;
    fail    = 1'b0;
    scan    = 1'b0;
    ignore  = 1'b0;

    if (ingest) begin
      if (accept) begin
        state_d = st_eff;
        case (st_eff)
          S_MARK: begin
            if (!sts_i.mark_ok) begin
              fail = 1'b1;
            end else if (sts_i.mark_end) begin
              state_d      = S_LEN;
              cmd_o.cnt_op = CNT_CLR;
            end else begin
              cmd_o.cnt_op = CNT_INC;
            end
          end
          S_LEN: begin
            cmd_o.len_shift = 1'b1;
            if (sts_i.len_end) begin
              if (sts_i.len_short) begin
                fail = 1'b1;
              end else begin
                state_d      = S_HDR;
                cmd_o.cnt_op = CNT_CLR;
              end
            end else begin
              cmd_o.cnt_op = CNT_INC;
            end
          end
          S_HDR: begin
            if (!sts_i.hdr_ok) begin
              fail = 1'b1;
            end else if (sts_i.hdr_end) begin
              if (sts_i.plen_bad) begin
                fail = 1'b1;
              end else begin
                state_d         = S_PAY;
                cmd_o.cnt_op    = CNT_CLR;
                cmd_o.plen_load = 1'b1;
              end
            end else begin
              cmd_o.cnt_op = CNT_INC;
            end
          end
          S_PAY: begin
            cmd_o.mem_wr = 1'b1;
            cmd_o.cnt_op = CNT_INC;
            if (sts_i.pay_end) begin
              // fetch bytes 0..3: byte order mark and tag mark
              scan         = 1'b1;
              cmd_o.ptr_op = PTR_ZERO;
              fcnt_d       = 2'd3;
              ret_d        = S_CK1;
              state_d      = S_FRD;
            end
          end
          default: begin
            ignore = 1'b1;
          end
        endcase
        if (!fail && !scan && !ignore && last_byte_i) begin
          fail = 1'b1;
        end
        if (fail) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_fail = 1'b1;
          state_d        = S_DONE;
        end
      end
    end else begin
      case (state_q)
        S_FRD: begin
          cmd_o.rd = 1'b1;
          state_d  = S_FSH;
        end
        S_FSH: begin
          cmd_o.shift = 1'b1;
          if (fcnt_q == 2'd0) begin
            state_d = ret_q;
          end else begin
            fcnt_d  = fcnt_q - 2'd1;
            state_d = S_FRD;
          end
        end
        S_CK1: begin
          if (!(sts_i.mark_mm || sts_i.mark_ii) || !sts_i.tag_ok) begin
            if (sts_i.out_free) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_fail = 1'b1;
              state_d        = S_DONE;
            end
          end else begin
            // read pointer already sits at byte 4: fetch the IFD offset
            cmd_o.le_load = 1'b1;
            fcnt_d        = 2'd3;
            ret_d         = S_CK2;
            state_d       = S_FRD;
          end
        end
        S_CK2: begin
          if (sts_i.off_bad) begin
            if (sts_i.out_free) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_fail = 1'b1;
              state_d        = S_DONE;
            end
          end else begin
            cmd_o.ptr_op = PTR_OFF;
            cmd_o.idx_op = IDX_OFF2;
            fcnt_d       = 2'd1;
            ret_d        = S_CK3;
            state_d      = S_FRD;
          end
        end
        S_CK3: begin
          cmd_o.ent_op = ENT_LOAD;
          state_d      = S_LOOP;
        end
        S_LOOP: begin
          if (sts_i.scan_end) begin
            if (sts_i.out_free) begin
              cmd_o.res_load = 1'b1;
              state_d        = S_DONE;
            end
          end else begin
            cmd_o.ptr_op = PTR_IDX;
            fcnt_d       = 2'd1;
            ret_d        = S_TAG;
            state_d      = S_FRD;
          end
        end
        S_TAG: begin
          if (sts_i.tag_hit) begin
            cmd_o.ptr_op = PTR_VAL;
            fcnt_d       = 2'd1;
            ret_d        = S_VAL;
            state_d      = S_FRD;
          end else begin
            cmd_o.ent_op = ENT_DEC;
            cmd_o.idx_op = IDX_STEP;
            state_d      = S_LOOP;
          end
        end
        S_VAL: begin
          if (sts_i.out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_val  = 1'b1;
            state_d        = S_DONE;
          end
        end
        default: begin
          state_d = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_MARK;
      ret_q   <= S_MARK;
      fcnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fcnt_q  <= fcnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> sts_i.out_free)
    else $error("result loaded while previous item still pending");

  a_fetch_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRD || state_q == S_FSH) |-> !in_ready_o)
    else $error("input taken during payload fetch");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && state_q == S_DONE && !first_byte_i) |-> !cmd_o.res_load)
    else $error("second result for one file");
`endif

endmodule

FILE: rtl/core/exif_orientation_extractor_top.sv
// Exif orientation extractor: finds tag 0x0112 in the first IFD of a JPEG APP1
// segment fed one byte per item.
// Input channel: in_valid_i/in_ready_o with data_byte_i, first_byte_i, last_byte_i.
//   first_byte_i restarts parsing with that byte as byte 0 of a new file.
// Output channel: out_valid_o/out_ready_i with failed_o, orientation_o; one item
//   per file. Bad markers, length or header fail on the offending byte; last_byte_i
//   before a result fails on that byte. Bytes after the result are dropped.
// Header and payload bytes are taken one per cycle while the output register is
//   free. After the last payload byte input stalls while the IFD is scanned through
//   the single read port of the payload store, one byte at a time: byte order and
//   tag marks, the IFD offset, the entry count, then the tag of each entry until
//   the tag is reached, and then its value.
// A header failure loads its result in the cycle the byte is accepted; the item
//   shows on the output in the cycle after.
// The output register holds one item. While it is full and out_ready_i is low, no
//   new byte is taken and the scan holds its result.
// Reset (rst_ni low, asynchronous) empties the output and returns to marker
//   search; the payload store is not cleared, every scanned entry is written first.
// MAX_PAYLOAD sets the payload store depth (12 to 65536 bytes).
`timescale 1ns / 1ps

module exif_orientation_extractor_top #(
  parameter int unsigned MAX_PAYLOAD = eoe_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        failed_o,
  output logic [15:0] orientation_o
);
  import eoe_pkg::*;

  eoe_cmd_t cmd;
  eoe_sts_t sts;

  eoe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  eoe_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .failed_o      (failed_o),
    .orientation_o (orientation_o)
  );

endmodule

FILE: verif/exif_orientation_extractor_top_test.sv
// Testbench for exif_orientation_extractor_top: random and directed JPEG/Exif byte
// streams, an in-bench orientation predictor and a result scoreboard.
// Depends only on the RTL of exif_orientation_extractor_top.
`timescale 1ns / 1ps

module exif_orientation_extractor_top_test;

  localparam int unsigned TIFF_STORE_DEPTH = 4096;
  localparam int unsigned HOLD_CYCLES      = 600;
  localparam int unsigned WATCHDOG_LIMIT   = 20000;
  localparam int unsigned PHASE_ITEMS      = 150;
  localparam int unsigned DRAIN_CYCLES     = 50;
  localparam int unsigned MAX_PRINTED      = 40;

  localparam logic [15:0] TAG_ORIENTATION = 16'h0112;
  localparam logic [15:0] TIFF_MARK       = 16'd42;
  localparam logic [15:0] ORDER_MM        = 16'h4D4D;
  localparam logic [15:0] ORDER_II        = 16'h4949;
  localparam logic [15:0] APP1_HDR_BYTES  = 16'd8;
  localparam int unsigned MIN_TIFF_BYTES  = 12;
  localparam int unsigned IFD_ENTRY_BYTES = 12;
  localparam int unsigned VALUE_FIELD     = 8;

  localparam logic [7:0] SOI_APP1 [4] = '{8'hFF, 8'hD8, 8'hFF, 8'hE1};
  localparam logic [7:0] EXIF_ID  [4] = '{8'h45, 8'h78, 8'h69, 8'h66};

  typedef enum logic [2:0] {
    ST_MARKERS,
    ST_LENGTH,
    ST_HEADER,
    ST_PAYLOAD,
    ST_DONE
  } parse_st_e;

  typedef enum logic [1:0] {
    FILE_RANDOM,
    FILE_CLEAN,
    FILE_FULL_SCAN
  } file_mode_e;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
  } jpeg_byte_t;

  typedef struct {
    logic        failed;
    logic [15:0] orient;
  } orient_result_t;

  typedef logic [7:0] byte_seq_t [$];

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i   = 8'h00;
  logic        first_byte_i  = 1'b0;
  logic        last_byte_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic        failed_o;
  logic [15:0] orientation_o;

  exif_orientation_extractor_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .failed_o      (failed_o),
    .orientation_o (orientation_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  jpeg_byte_t     byte_q [$];
  orient_result_t pending_results [$];
  logic [7:0]     tiff_buf [];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          in_busy      = 1'b0;
  bit          hold_go      = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned err_cnt      = 0;
  int unsigned n_items      = 0;
  int unsigned n_files      = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_results    = 0;
  int unsigned n_fail_res   = 0;
  int unsigned n_tag_res    = 0;
  int unsigned quiet_cycles = 0;

  // predictor state
  parse_st_e   parse_st    = ST_MARKERS;
  int unsigned step_cnt    = 0;
  logic [15:0] seg_len     = 16'd0;
  bit          le_order    = 1'b0;
  bit          result_sent = 1'b0;
  logic [7:0]  tiff_store [TIFF_STORE_DEPTH];

  task automatic flag_error(input string msg);
    if (err_cnt < MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic [31:0] rd8(input logic [31:0] i);
    return (i < TIFF_STORE_DEPTH) ? {24'd0, tiff_store[i]} : 32'd0;
  endfunction

  function automatic logic [31:0] rd16(input logic [31:0] i);
    if (le_order) return (rd8(i + 1) << 8) | rd8(i);
    return (rd8(i) << 8) | rd8(i + 1);
  endfunction

  function automatic logic [31:0] rd32(input logic [31:0] i);
    if (le_order) return (rd16(i + 2) << 16) | rd16(i);
    return (rd16(i) << 16) | rd16(i + 2);
  endfunction

  // -1 on a bad TIFF header, else the orientation value (0 when absent)
  function automatic int scan_tiff();
    logic [31:0] plen, ofs, left, idx;
    logic [15:0] mark;
    plen = {16'd0, seg_len};
    mark = {tiff_store[0], tiff_store[1]};
    if (mark == ORDER_MM) le_order = 1'b0;
    else if (mark == ORDER_II) le_order = 1'b1;
    else return -1;
    if (rd16(2) != {16'd0, TIFF_MARK}) return -1;
    ofs = rd32(4);
    if (ofs > plen - 2) return -1;
    left = rd16(ofs);
    idx = ofs + 2;
    while (left > 0 && idx < plen - IFD_ENTRY_BYTES) begin
      if (rd16(idx) == {16'd0, TAG_ORIENTATION}) return int'(rd16(idx + VALUE_FIELD));
      left--;
      idx += IFD_ENTRY_BYTES;
    end
    return 0;
  endfunction

  function automatic void predict_orientation(input logic [7:0] d, input logic fb,
                                              input logic lb);
    int             res;
    orient_result_t r;
    res = -2;
    if (fb) begin
      parse_st    = ST_MARKERS;
      step_cnt    = 0;
      seg_len     = 16'd0;
      le_order    = 1'b0;
      result_sent = 1'b0;
    end
    if (result_sent) return;
    case (parse_st)
      ST_MARKERS: begin
        if (d != SOI_APP1[step_cnt[1:0]]) res = -1;
        else if (++step_cnt == 4) begin
          parse_st = ST_LENGTH;
          step_cnt = 0;
        end
      end
      ST_LENGTH: begin
        seg_len = {seg_len[7:0], d};
        if (++step_cnt == 2) begin
          if (seg_len < APP1_HDR_BYTES) res = -1;
          else begin
            parse_st = ST_HEADER;
            step_cnt = 0;
          end
        end
      end
      ST_HEADER: begin
        if (step_cnt < 4 && d != EXIF_ID[step_cnt[1:0]]) res = -1;
        else if (++step_cnt == 6) begin
          seg_len -= APP1_HDR_BYTES;
          if (seg_len < MIN_TIFF_BYTES || seg_len > TIFF_STORE_DEPTH) res = -1;
          else begin
            parse_st = ST_PAYLOAD;
            step_cnt = 0;
          end
        end
      end
      ST_PAYLOAD: begin
        if (step_cnt < TIFF_STORE_DEPTH) tiff_store[step_cnt] = d;
        if (++step_cnt >= seg_len) res = scan_tiff();
      end
      default: return;
    endcase
    if (res == -2 && lb) res = -1;
    if (res == -2) return;
    result_sent = 1'b1;
    parse_st    = ST_DONE;
    r.failed    = (res < 0);
    r.orient    = (res < 0) ? 16'd0 : res[15:0];
    pending_results.push_back(r);
  endfunction

  task automatic push_byte(input logic [7:0] d, input logic fb, input logic lb);
    jpeg_byte_t it;
    it.data  = d;
    it.first = fb;
    it.last  = lb;
    byte_q.push_back(it);
    n_items++;
  endtask

  task automatic send_seq(input byte_seq_t s, input logic fb, input logic lb);
    foreach (s[i]) push_byte(s[i], fb && i == 0, lb && i == s.size() - 1);
    n_files++;
  endtask

  function automatic void put16(input int unsigned pos, input logic [15:0] v, input bit le);
    if (pos + 1 < tiff_buf.size()) begin
      tiff_buf[pos]     = le ? v[7:0] : v[15:8];
      tiff_buf[pos + 1] = le ? v[15:8] : v[7:0];
    end
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1:       return 16'($urandom_range(1, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_file(input int unsigned plen, input file_mode_e mode);
    logic [7:0]  f [$];
    logic [15:0] seg;
    int unsigned ofs, cnt, hit_at, idx;
    bit          le, fb, lb;
    tiff_buf = new[plen];
    foreach (tiff_buf[i]) tiff_buf[i] = 8'($urandom);
    le = 1'($urandom_range(1));
    tiff_buf[0] = le ? ORDER_II[7:0] : ORDER_MM[7:0];
    tiff_buf[1] = tiff_buf[0];
    put16(2, TIFF_MARK, le);
    if (mode != FILE_RANDOM) ofs = 8;
    else begin
      case ($urandom_range(7))
        0:       ofs = $urandom;
        1:       ofs = plen - 2 + $urandom_range(1);
        default: ofs = $urandom_range(8, plen - 2);
      endcase
    end
    put16(4, le ? ofs[15:0] : ofs[31:16], le);
    put16(6, le ? ofs[31:16] : ofs[15:0], le);
    if (ofs <= plen - 2) begin
      if (mode == FILE_FULL_SCAN) cnt = 16'hFFFF;
      else if (mode == FILE_CLEAN) cnt = $urandom_range(1, 4);
      else cnt = ($urandom_range(7) == 0) ? 16'hFFFF : $urandom_range(12);
      hit_at = (mode == FILE_CLEAN) ? $urandom_range(cnt - 1) : $urandom_range(15);
      put16(ofs, cnt[15:0], le);
      idx = ofs + 2;
      for (int e = 0; idx + 10 <= plen && e < 400; e++) begin
        if (mode == FILE_FULL_SCAN) put16(idx, 16'h0100, le);
        else if (e == hit_at) put16(idx, TAG_ORIENTATION, le);
        else put16(idx, 16'($urandom_range(16'h0100, 16'h0120)), le);
        put16(idx + VALUE_FIELD, pick_value(), le);
        idx += IFD_ENTRY_BYTES;
      end
    end
    seg = 16'(plen) + APP1_HDR_BYTES;
    foreach (SOI_APP1[i]) f.push_back(SOI_APP1[i]);
    f.push_back(seg[15:8]);
    f.push_back(seg[7:0]);
    foreach (EXIF_ID[i]) f.push_back(EXIF_ID[i]);
    f.push_back(8'h00);
    f.push_back(8'h00);
    foreach (tiff_buf[i]) f.push_back(tiff_buf[i]);
    if (mode == FILE_RANDOM) begin
      case ($urandom_range(9))
        0: f[$urandom_range(11)] ^= 8'($urandom_range(1, 255));       // markers/length/Exif
        1: f[12 + $urandom_range(7)] ^= 8'($urandom_range(1, 255));   // byte order, 42, offset
        2: f[$urandom_range(f.size() - 1)] ^= 8'($urandom_range(1, 255));
        3: f = f[0:$urandom_range(f.size() - 1)];                     // truncated file
        default: ;
      endcase
      repeat ($urandom_range(2)) f.push_back(8'($urandom));          // trailing junk
    end
    fb = (mode != FILE_RANDOM) || ($urandom_range(19) != 0);
    lb = (mode != FILE_RANDOM) || ($urandom_range(5) != 0);
    send_seq(f, fb, lb);
  endtask

  // sender: one item in flight, held until accepted
  always @(negedge clk_i) begin : drive_bytes
    jpeg_byte_t nxt;
    if (rst_ni && !in_busy) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = byte_q.pop_front();
        in_valid_i   <= 1'b1;
        data_byte_i  <= nxt.data;
        first_byte_i <= nxt.first;
        last_byte_i  <= nxt.last;
        in_busy = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off so the block backs up into its input
  always @(negedge clk_i) begin : drain_results
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch_ports
    orient_result_t want;
    bit             fire_in, fire_out;
    fire_in  = rst_ni && in_valid_i && in_ready_o;
    fire_out = rst_ni && out_valid_o && out_ready_i;
    if (fire_in) begin
      predict_orientation(data_byte_i, first_byte_i, last_byte_i);
      in_busy = 1'b0;
      n_accepted++;
    end
    if (fire_out) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result failed=%0b orientation=%h with none expected",
                             failed_o, orientation_o));
      end else begin
        want = pending_results.pop_front();
        if (failed_o !== want.failed)
          flag_error($sformatf("failed=%b, expected %b", failed_o, want.failed));
        if (orientation_o !== want.orient)
          flag_error($sformatf("orientation=%h, expected %h", orientation_o, want.orient));
        n_results++;
        if (want.failed) n_fail_res++;
        if (want.orient != 16'd0) n_tag_res++;
      end
    end
    if (fire_in || fire_out || !rst_ni ||
        (byte_q.size() == 0 && !in_busy && pending_results.size() == 0)) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT @%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    byte_seq_t   noise;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      if (ph == 0) begin
        // first file after reset carries no first_byte flag; segment length below 8
        send_seq('{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h07}, 1'b0, 1'b0);
        send_seq('{8'h00}, 1'b1, 1'b0);
        send_seq('{8'hFF, 8'hD8, 8'hFF, 8'hE0}, 1'b1, 1'b0);
        send_seq('{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h08}, 1'b1, 1'b0);
        send_seq('{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h0B,
                   8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00}, 1'b1, 1'b0);
        // payload one byte over the store; trailing last byte is ignored
        send_seq('{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h10, 8'h09,
                   8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00, 8'h5A}, 1'b1, 1'b1);
        send_seq('{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'hFF, 8'hFF,
                   8'h45, 8'h78, 8'h69, 8'h66, 8'hFF, 8'hFF}, 1'b1, 1'b0);
        send_seq('{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h20,
                   8'h45, 8'h78, 8'h69, 8'h67}, 1'b1, 1'b0);
        send_seq('{8'hFF, 8'hD8}, 1'b1, 1'b1);
        // restart in the middle of a file
        send_seq('{8'hFF, 8'hD8, 8'hFF}, 1'b1, 1'b0);
        add_file(MIN_TIFF_BYTES, FILE_CLEAN);
        add_file(26, FILE_CLEAN);
        add_file(120, FILE_FULL_SCAN);
        hold_go = 1'b1;
      end
      target = n_items + PHASE_ITEMS;
      while (n_items < target) begin
        case ($urandom_range(11))
          0: begin
            noise.delete();
            repeat ($urandom_range(1, 6)) noise.push_back(8'($urandom));
            if ($urandom_range(1)) noise[0] = 8'hFF;
            send_seq(noise, 1'($urandom_range(1)), 1'($urandom_range(1)));
          end
          1:       add_file($urandom_range(60, 700), FILE_RANDOM);
          2:       add_file($urandom_range(12, 60), FILE_CLEAN);
          default: add_file($urandom_range(12, 60), FILE_RANDOM);
        endcase
      end
      while (byte_q.size() != 0 || in_busy) @(posedge clk_i);
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d bytes accepted over %0d files, %0d results (%0d failures, %0d nonzero).",
             n_accepted, n_files, n_results, n_fail_res, n_tag_res);
    $display("Idle mixes: none, sender 67%%, receiver 67%%, both 24%%, plus one %0d-cycle hold.",
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/eoe_pkg.sv
rtl/core/eoe_dp.sv
rtl/core/eoe_ctrl.sv
rtl/core/exif_orientation_extractor_top.sv
verif/exif_orientation_extractor_top_test.sv
